>>> rtl/line_rasterizer_defines.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define LR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lr_pkg.sv
// Shared types and constants of the line rasterizer.
package lr_pkg;

	localparam int WIN_W     = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [WIN_W-1:0] WIN_RESET = 11'd700;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd1;

	// Command word kinds
	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_STEP = 1'b1
	} lr_kind_t;

	// Classification of one queued command word
	typedef struct packed {
		logic is_load;
		logic step_x_neg;
		logic step_y_neg;
		logic x_major;
	} lr_ctl_t;

	// Queue fill status
	typedef struct packed {
		logic empty;
		logic full;
	} lr_qstat_t;

	// Back-end status
	typedef struct packed {
		logic active;
		logic out_pending;
	} lr_bstat_t;

endpackage

>>> rtl/lr_channels.sv
// Channel interfaces of the line rasterizer: commands, pixels, configuration.
interface lr_cmd_if #(parameter int COORD_BITS = 12) ();
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source(output valid, kind, start_x, start_y, end_x, end_y, input ready);
	modport sink(input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pixel_if #(parameter int COORD_BITS = 12) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         visible;
	logic                         last;

	modport source(output valid, pixel_x, pixel_y, visible, last, input ready);
	modport sink(input valid, pixel_x, pixel_y, visible, last, output ready);
endinterface

interface lr_cfg_if ();
	logic                          valid;
	logic                          ready;
	logic [lr_pkg::CFG_IDX_W-1:0]  index;
	logic [lr_pkg::WIN_W-1:0]      data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/lr_front.sv
// Front end: accepts command words, computes deltas, directions and major axis.
module lr_front #(
	parameter int COORD_BITS = 12
) (
	lr_cmd_if.sink                  cmd,
	input  logic                    full,
	output logic                    push,
	output lr_pkg::lr_ctl_t         ctl,
	output logic [COORD_BITS-1:0]   abs_dx,
	output logic [COORD_BITS-1:0]   abs_dy
);
	import lr_pkg::*;

	localparam int C = COORD_BITS;

	logic [C:0] dx;
	logic [C:0] dy;
	logic [C:0] neg_dx;
	logic [C:0] neg_dy;

	// Take a word whenever the queue has room
	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	// Signed deltas, one bit wider than a coordinate
	assign dx     = {cmd.end_x[C-1], cmd.end_x} - {cmd.start_x[C-1], cmd.start_x};
	assign dy     = {cmd.end_y[C-1], cmd.end_y} - {cmd.start_y[C-1], cmd.start_y};
	assign neg_dx = (~dx) + (C+1)'(1);
	assign neg_dy = (~dy) + (C+1)'(1);

	// Magnitudes always fit a coordinate width
	assign abs_dx = dx[C] ? neg_dx[C-1:0] : dx[C-1:0];
	assign abs_dy = dy[C] ? neg_dy[C-1:0] : dy[C-1:0];

	// Classify: a zero delta takes the negative direction
	always_comb begin
		ctl.is_load    = (lr_kind_t'(cmd.kind) == KIND_LOAD);
		ctl.step_x_neg = dx[C] || (dx == '0);
		ctl.step_y_neg = dy[C] || (dy == '0);
		ctl.x_major    = (abs_dx > abs_dy);
	end

endmodule

>>> rtl/lr_queue.sv
// Short FIFO between the front end and the back end.
module lr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output lr_pkg::lr_qstat_t stat
);
	import lr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rdata      = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/lr_back.sv
// Back end: holds the line state, steps the error term, registers one pixel.
module lr_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  lr_pkg::lr_ctl_t                head_ctl,
	input  logic signed [COORD_BITS-1:0]   head_start_x,
	input  logic signed [COORD_BITS-1:0]   head_start_y,
	input  logic signed [COORD_BITS-1:0]   head_end_x,
	input  logic signed [COORD_BITS-1:0]   head_end_y,
	input  logic [COORD_BITS-1:0]          head_abs_dx,
	input  logic [COORD_BITS-1:0]          head_abs_dy,
	input  logic [lr_pkg::WIN_W-1:0]       window_width,
	input  logic [lr_pkg::WIN_W-1:0]       window_height,
	output logic                           pop,
	output lr_pkg::lr_bstat_t              stat,
	lr_pixel_if.source                     pixel
);
	import lr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int E_W   = COORD_BITS + 1;
	localparam int CMP_W = (COORD_BITS > WIN_W) ? COORD_BITS : WIN_W;

	// Line state
	logic signed [C-1:0] cur_x_q;
	logic signed [C-1:0] cur_y_q;
	logic signed [C-1:0] goal_x_q;
	logic signed [C-1:0] goal_y_q;
	logic [C-1:0]        abs_dx_q;
	logic [C-1:0]        abs_dy_q;
	logic [E_W-1:0]      err_q;
	logic                step_x_neg_q;
	logic                step_y_neg_q;
	logic                x_major_q;
	logic                active_q;

	// Output register
	logic                out_valid_q;
	logic signed [C-1:0] px_q;
	logic signed [C-1:0] py_q;
	logic                vis_q;
	logic                last_q;

	logic                out_free;
	logic                emit;
	logic                at_end;
	logic signed [C-1:0] emit_x;
	logic signed [C-1:0] emit_y;
	logic                emit_vis;
	logic [C-1:0]        major;
	logic [C-1:0]        minor;
	logic [C-1:0]        head_major;
	logic [E_W-1:0]      err_sub;
	logic [E_W-1:0]      err_add;
	logic                borrow;
	logic [C-1:0]        x_next;
	logic [C-1:0]        y_next;

	// Loads drain freely; steps wait for a free output slot
	assign out_free = !out_valid_q || pixel.ready;
	assign pop      = !q_empty && (head_ctl.is_load || out_free);
	assign emit     = pop && !head_ctl.is_load && active_q;

	// Pick the pixel: the goal point once the major axis reaches it
	assign at_end = x_major_q ? (cur_x_q == goal_x_q) : (cur_y_q == goal_y_q);
	assign emit_x = at_end ? goal_x_q : cur_x_q;
	assign emit_y = at_end ? goal_y_q : cur_y_q;

	// Clip against the window
	assign emit_vis = !emit_x[C-1] && (CMP_W'(emit_x[C-2:0]) < CMP_W'(window_width)) &&
	                  !emit_y[C-1] && (CMP_W'(emit_y[C-2:0]) < CMP_W'(window_height));

	// Error update: subtract minor delta, add major back on borrow
	assign major   = x_major_q ? abs_dx_q : abs_dy_q;
	assign minor   = x_major_q ? abs_dy_q : abs_dx_q;
	assign err_sub = err_q - {1'b0, minor};
	assign err_add = err_sub + {1'b0, major};
	assign borrow  = err_sub[E_W-1];

	assign x_next = step_x_neg_q ? cur_x_q - C'(1) : cur_x_q + C'(1);
	assign y_next = step_y_neg_q ? cur_y_q - C'(1) : cur_y_q + C'(1);

	assign head_major = head_ctl.x_major ? head_abs_dx : head_abs_dy;

	// Hold line state; load or step on each popped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			abs_dx_q     <= '0;
			abs_dy_q     <= '0;
			err_q        <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			x_major_q    <= 1'b0;
			active_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop && head_ctl.is_load) begin
				cur_x_q      <= head_start_x;
				cur_y_q      <= head_start_y;
				goal_x_q     <= head_end_x;
				goal_y_q     <= head_end_y;
				abs_dx_q     <= head_abs_dx;
				abs_dy_q     <= head_abs_dy;
				err_q        <= {2'b00, head_major[C-1:1]};
				step_x_neg_q <= head_ctl.step_x_neg;
				step_y_neg_q <= head_ctl.step_y_neg;
				x_major_q    <= head_ctl.x_major;
				active_q     <= 1'b1;
			end else if (emit) begin
				if (at_end) begin
					active_q <= 1'b0;
				end else begin
					err_q <= borrow ? err_add : err_sub;
					if (x_major_q || borrow) begin
						cur_x_q <= x_next;
					end
					if (!x_major_q || borrow) begin
						cur_y_q <= y_next;
					end
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pixel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the pixel word
	always_ff @(posedge clk) begin
		if (emit) begin
			px_q   <= emit_x;
			py_q   <= emit_y;
			vis_q  <= emit_vis;
			last_q <= at_end;
		end
	end

	assign pixel.valid   = out_valid_q;
	assign pixel.pixel_x = px_q;
	assign pixel.pixel_y = py_q;
	assign pixel.visible = vis_q;
	assign pixel.last    = last_q;

	assign stat.active      = active_q;
	assign stat.out_pending = out_valid_q;

endmodule

>>> rtl/line_rasterizer.sv
// Top level of the Bresenham line rasterizer with window clipping.
//
//   channel  dir  word                                       handshake
//   cmd      in   kind, start_x, start_y, end_x, end_y       valid/ready
//   pixel    out  pixel_x, pixel_y, visible, last            valid/ready
//   cfg      in   index, data (window_width, window_height)  valid/ready, always ready
//
// One command word per clock until the queue fills; a step word's pixel is registered
// as it leaves the queue, so pixels stream at one per clock unless the output stalls,
// paced by the back-end error add/compare and the single output register.
// Reset clears the line state and queue and sets both window registers to 700.
// A stalled pixel output holds steps in the queue; the front keeps taking words
// until the queue of QUEUE_DEPTH entries fills.
`include "line_rasterizer_defines.svh"

module line_rasterizer #(
	parameter int COORD_BITS  = 12,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	lr_cmd_if.sink     cmd,
	lr_pixel_if.source pixel,
	lr_cfg_if.sink     cfg
);
	import lr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int ENT_W = 6 * COORD_BITS + $bits(lr_ctl_t);

	logic [WIN_W-1:0] window_width_q;
	logic [WIN_W-1:0] window_height_q;

	logic             push;
	logic             pop;
	lr_ctl_t          f_ctl;
	logic [C-1:0]     f_abs_dx;
	logic [C-1:0]     f_abs_dy;
	logic [ENT_W-1:0] q_wdata;
	logic [ENT_W-1:0] q_rdata;
	lr_qstat_t        q_stat;
	lr_bstat_t        b_stat;

	lr_ctl_t             h_ctl;
	logic signed [C-1:0] h_start_x;
	logic signed [C-1:0] h_start_y;
	logic signed [C-1:0] h_end_x;
	logic signed [C-1:0] h_end_y;
	logic [C-1:0]        h_abs_dx;
	logic [C-1:0]        h_abs_dy;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q  <= WIN_RESET;
			window_height_q <= WIN_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_WINDOW_WIDTH) begin
				window_width_q <= cfg.data;
			end else if (cfg.index == REG_WINDOW_HEIGHT) begin
				window_height_q <= cfg.data;
			end
		end
	end

	// Classify incoming words
	lr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.cmd    (cmd),
		.full   (q_stat.full),
		.push   (push),
		.ctl    (f_ctl),
		.abs_dx (f_abs_dx),
		.abs_dy (f_abs_dy)
	);

	// Queue the classified words
	assign q_wdata = {f_ctl, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y, f_abs_dx, f_abs_dy};

	lr_queue #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.pop    (pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	assign {h_ctl, h_start_x, h_start_y, h_end_x, h_end_y, h_abs_dx, h_abs_dy} = q_rdata;

	// Execute loads and steps
	lr_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_stat.empty),
		.head_ctl      (h_ctl),
		.head_start_x  (h_start_x),
		.head_start_y  (h_start_y),
		.head_end_x    (h_end_x),
		.head_end_y    (h_end_y),
		.head_abs_dx   (h_abs_dx),
		.head_abs_dy   (h_abs_dy),
		.window_width  (window_width_q),
		.window_height (window_height_q),
		.pop           (pop),
		.stat          (b_stat),
		.pixel         (pixel)
	);

	// An empty queue cannot start a new pixel word
	`LR_ASSERT_NEXT(a_no_pixel_from_empty, q_stat.empty, !$rose(pixel.valid), "pixel from empty queue")

	// A line ends only by issuing its last pixel
	`LR_ASSERT_NOW(a_end_with_last, $fell(b_stat.active), pixel.valid && pixel.last, "line ended without last pixel")

	// Visible pixels have non-negative coordinates
	`LR_ASSERT_NOW(a_visible_nonneg, pixel.valid && pixel.visible, !pixel.pixel_x[COORD_BITS-1] && !pixel.pixel_y[COORD_BITS-1], "visible pixel off window")

	// Output register state matches the pixel channel
	`LR_ASSERT_NOW(a_pending_matches, 1'b1, b_stat.out_pending == pixel.valid, "output register out of step")

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the line rasterizer: directed and random lines under window sweeps.
module tb;
	import lr_pkg::*;

	localparam int COORD_BITS   = 12;
	localparam int COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;
	localparam int COORD_MIN    = -(2 ** (COORD_BITS - 1));
	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_HOLD    = 120;
	localparam int PHASE_ITEMS  = 250;

	// Index with no register behind it; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [COORD_BITS-1:0]        delta_t;
	typedef logic signed [COORD_BITS:0]   err_t;

	typedef struct {
		coord_t x;
		coord_t y;
		logic   visible;
		logic   last;
	} pixel_t;

	// Bresenham line walker that tracks the block and queues the pixels it owes
	class pixel_predictor;
		logic [WIN_W-1:0] win_w = WIN_RESET;
		logic [WIN_W-1:0] win_h = WIN_RESET;
		coord_t cur_x = '0, cur_y = '0, goal_x = '0, goal_y = '0;
		delta_t abs_dx = '0, abs_dy = '0;
		err_t   err = '0;
		logic   x_neg = 1'b0, y_neg = 1'b0, x_major = 1'b0, live = 1'b0;
		pixel_t pending_pixels[$];
		int     mismatches = 0;

		function void write_window(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
			case (idx)
			REG_WINDOW_WIDTH:  win_w = val;
			REG_WINDOW_HEIGHT: win_h = val;
			default: ;
			endcase
		endfunction

		function coord_t step_coord(coord_t c, logic neg);
			return neg ? c - 1'b1 : c + 1'b1;
		endfunction

		function void push_pixel(coord_t x, coord_t y, logic is_last);
			pixel_t p;
			p.x = x;
			p.y = y;
			p.last = is_last;
			p.visible = (x >= 0) && (int'(x) < int'(win_w)) &&
				(y >= 0) && (int'(y) < int'(win_h));
			pending_pixels.push_back(p);
		endfunction

		// Apply one accepted command word; return 1 unless the block ignores it
		function bit note_command(lr_kind_t kind, coord_t sx, coord_t sy,
				coord_t ex, coord_t ey);
			int dx, dy;
			if (kind == KIND_LOAD) begin
				cur_x = sx;
				cur_y = sy;
				goal_x = ex;
				goal_y = ey;
				dx = int'(ex) - int'(sx);
				dy = int'(ey) - int'(sy);
				x_neg = !(dx > 0);
				y_neg = !(dy > 0);
				abs_dx = delta_t'(dx < 0 ? -dx : dx);
				abs_dy = delta_t'(dy < 0 ? -dy : dy);
				x_major = abs_dx > abs_dy;
				err = $signed({1'b0, (x_major ? abs_dx : abs_dy)} >> 1);
				live = 1'b1;
				return 1'b1;
			end
			if (!live)
				return 1'b0;
			// end point reached on the major axis
			if (x_major ? (cur_x == goal_x) : (cur_y == goal_y)) begin
				push_pixel(goal_x, goal_y, 1'b1);
				live = 1'b0;
				return 1'b1;
			end
			push_pixel(cur_x, cur_y, 1'b0);
			if (x_major) begin
				err = err - $signed({1'b0, abs_dy});
				if (err < 0) begin
					cur_y = step_coord(cur_y, y_neg);
					err = err + $signed({1'b0, abs_dx});
				end
				cur_x = step_coord(cur_x, x_neg);
			end else begin
				err = err - $signed({1'b0, abs_dx});
				if (err < 0) begin
					cur_x = step_coord(cur_x, x_neg);
					err = err + $signed({1'b0, abs_dy});
				end
				cur_y = step_coord(cur_y, y_neg);
			end
			return 1'b1;
		endfunction

		// Compare one accepted pixel word with the oldest one owed
		function void check_pixel(coord_t x, coord_t y, logic vis, logic is_last);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$error("pixel (%0d,%0d) arrived with none expected", x, y);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			if (x !== want.x) begin
				$error("pixel_x: expected %0d, got %0d", want.x, x);
				mismatches++;
			end
			if (y !== want.y) begin
				$error("pixel_y: expected %0d, got %0d", want.y, y);
				mismatches++;
			end
			if (vis !== want.visible) begin
				$error("visible: expected %0b, got %0b", want.visible, vis);
				mismatches++;
			end
			if (is_last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, is_last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic hold_off_req;
	int   useful_words;

	pixel_predictor predictor = new;

	lr_cmd_if #(.COORD_BITS(COORD_BITS))   cmd_ch ();
	lr_pixel_if #(.COORD_BITS(COORD_BITS)) pix_ch ();
	lr_cfg_if                              cfg_ch ();

	line_rasterizer #(.COORD_BITS(COORD_BITS)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.pixel (pix_ch),
		.cfg   (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none at all in calm stretches
	function automatic int gap_cycles(logic calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic coord_t near(int c, int spread);
		int v;
		v = c + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return coord_t'(v);
	endfunction

	// Pick anywhere, around the origin, or around the far window edge
	function automatic coord_t pick_coord(logic [WIN_W-1:0] lim);
		case ($urandom_range(0, 2))
		0: return coord_t'($urandom);
		1: return near(0, 24);
		default: return near(int'(lim), 24);
		endcase
	endfunction

	task automatic send_word(lr_kind_t kind, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		cmd_ch.valid   <= 1'b1;
		cmd_ch.kind    <= kind;
		cmd_ch.start_x <= sx;
		cmd_ch.start_y <= sy;
		cmd_ch.end_x   <= ex;
		cmd_ch.end_y   <= ey;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		if (predictor.note_command(kind, sx, sy, ex, ey))
			useful_words++;
	endtask

	task automatic load_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		send_word(KIND_LOAD, sx, sy, ex, ey);
	endtask

	// Endpoint fields are don't-care on a step; fill them with noise
	task automatic step_once();
		send_word(KIND_STEP, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom));
	endtask

	task automatic pause_cmd(int n);
		if (n > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every owed pixel is out and the queue has settled
	task automatic drain_pixels();
		cmd_ch.valid <= 1'b0;
		while (predictor.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		predictor.write_window(idx, val);
	endtask

	task automatic set_window(logic [WIN_W-1:0] w, logic [WIN_W-1:0] h);
		drain_pixels();
		write_reg(REG_WINDOW_WIDTH, w);
		write_reg(REG_WINDOW_HEIGHT, h);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_directed();
		// step with no line loaded
		step_once();
		pause_cmd(gap_cycles(1'b0));
		// zero-length line, then a step after its end
		load_line(coord_t'(5), coord_t'(-5), coord_t'(5), coord_t'(-5));
		repeat (2) step_once();
		pause_cmd(gap_cycles(1'b0));
		// extreme corners, replaced by the next load before the end
		load_line(coord_t'(COORD_MIN), coord_t'(COORD_MAX),
			coord_t'(COORD_MAX), coord_t'(COORD_MIN));
		repeat (3) step_once();
		pause_cmd(gap_cycles(1'b0));
		load_line(coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(1));
		repeat (4) step_once();
		pause_cmd(gap_cycles(1'b0));
		// x major, walking toward negative x
		load_line(coord_t'(COORD_MAX), coord_t'(COORD_MIN),
			coord_t'(COORD_MIN), coord_t'(COORD_MIN + 1));
		repeat (2) step_once();
		pause_cmd(gap_cycles(1'b0));
		// zero x delta
		load_line(coord_t'(10), coord_t'(3), coord_t'(10), coord_t'(1));
		repeat (3) step_once();
		pause_cmd(gap_cycles(1'b0));
		// straddle the default window edge
		load_line(coord_t'(699), coord_t'(699), coord_t'(700), coord_t'(700));
		repeat (2) step_once();
	endtask

	// One load and its steps: mostly complete lines, some cut short, some overrun
	task automatic random_line();
		coord_t sx, sy, ex, ey;
		int     adx, ady, major, steps, r;
		logic   calm;
		calm = ($urandom_range(0, 3) == 0);
		sx = pick_coord(predictor.win_w);
		sy = pick_coord(predictor.win_h);
		if ($urandom_range(0, 99) < 6) begin
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
		end else begin
			ex = near(sx, 20);
			ey = near(sy, 20);
		end
		adx = int'(ex) - int'(sx);
		ady = int'(ey) - int'(sy);
		if (adx < 0)
			adx = -adx;
		if (ady < 0)
			ady = -ady;
		major = adx > ady ? adx : ady;
		r = $urandom_range(0, 99);
		if (r < 10 || major > 40)
			steps = $urandom_range(0, major < 30 ? major : 30);
		else if (r < 20)
			steps = major + 1 + $urandom_range(1, 3);
		else
			steps = major + 1;
		load_line(sx, sy, ex, ey);
		pause_cmd(gap_cycles(calm));
		repeat (steps) begin
			step_once();
			pause_cmd(gap_cycles(calm));
		end
	endtask

	task automatic run_phase(logic with_stall);
		int target;
		// stall the pixel side while steps keep coming, so the queue fills
		if (with_stall) begin
			load_line(coord_t'(0), coord_t'(0), coord_t'(60), coord_t'(13));
			hold_off_req = 1'b1;
			repeat (61) step_once();
		end
		target = useful_words + PHASE_ITEMS;
		while (useful_words < target)
			random_line();
	endtask

	// Check every accepted pixel word
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready)
			predictor.check_pixel(pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.visible, pix_ch.last);
	end

	// Pixel side: random ready, with the long hold when requested
	initial begin : pixel_sink
		int   n;
		logic calm;
		pix_ch.ready = 1'b0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				pix_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if ($urandom_range(0, 15) == 0)
				calm = !calm;
			n = gap_cycles(calm);
			if (n > 0) begin
				pix_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		arst_n         = 1'b0;
		hold_off_req   = 1'b0;
		useful_words   = 0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.kind    = KIND_LOAD;
		cmd_ch.start_x = '0;
		cmd_ch.start_y = '0;
		cmd_ch.end_x   = '0;
		cmd_ch.end_y   = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_WINDOW_WIDTH;
		cfg_ch.data    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window first
		run_directed();
		run_phase(1'b1);

		// zero width, full range, a one-pixel window, then zero height
		set_window(WIN_W'(0), WIN_W'(300));
		run_phase(1'b0);
		set_window(WIN_W'(2047), WIN_W'(2047));
		run_phase(1'b0);
		set_window(WIN_W'(1), WIN_W'(1));
		run_phase(1'b0);
		set_window(WIN_W'(300), WIN_W'(0));
		run_phase(1'b0);

		// random window; the unused index must leave it alone
		drain_pixels();
		write_reg(REG_WINDOW_WIDTH, WIN_W'($urandom_range(1, 2047)));
		write_reg(REG_WINDOW_HEIGHT, WIN_W'($urandom_range(1, 2047)));
		write_reg(REG_UNUSED, WIN_W'($urandom));
		cfg_ch.valid <= 1'b0;
		run_phase(1'b0);

		drain_pixels();
		if (predictor.mismatches == 0 && predictor.pending_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> line_rasterizer.f
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_channels.sv
rtl/lr_front.sv
rtl/lr_queue.sv
rtl/lr_back.sv
rtl/line_rasterizer.sv
sim/tb.sv
